FILE: rtl/core/http_chunked_body_decoder_macros.svh
// Assertion macros for the chunked body decoder.
// Included by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define HCBD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HCBD_ASSERT(lbl, prop, msg)
`define HCBD_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/hcbd_pkg.sv
// Shared types and constants of the chunked body decoder.
// No dependencies; imported by the interfaces and every module.
package hcbd_pkg;

  // Result kinds
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_FRAME    = 3'd0;
  localparam kind_t KIND_PAYLOAD  = 3'd1;
  localparam kind_t KIND_COMPLETE = 3'd2;
  localparam kind_t KIND_ERROR    = 3'd3;
  localparam kind_t KIND_IGNORED  = 3'd4;

  // APB register map
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_MAX_LINE_ADDR = 2'd0;
  localparam logic [7:0] MAX_LINE_RESET = 8'd64;

  // One stream byte with its character class worked out
  typedef struct packed {
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
  } byte_class_t;

endpackage

FILE: rtl/core/hcbd_ifs.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on hcbd_pkg for the kind type.
interface hcbd_stream_if import hcbd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface hcbd_result_if import hcbd_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] payload_byte;
  logic       chunk_end;

  modport source (output valid, output kind, output payload_byte, output chunk_end, input ready);
  modport sink (input valid, input kind, input payload_byte, input chunk_end, output ready);
endinterface

FILE: rtl/core/http_chunked_body_decoder.sv
// HTTP chunked body decoder. Takes one body byte per item and returns one
// result per byte (framing, payload, body complete, error or ignored), and
// sustains one byte per clock on both channels while the result sink is ready.
// An accepted byte is registered with its class in the front register, written
// into the queue, then taken through the parser into the result register;
// the per-byte parser step, with its SIZE_BITS-wide count decrement and zero test,
// sets the clock. The queue of QUEUE_DEPTH bytes lets input and output stall
// independently. max_line_length lives at APB byte address 0 and resets to 64;
// write it only while the decoder is idle. After body end or an error every
// byte reads as ignored until reset.
`include "http_chunked_body_decoder_macros.svh"
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int SIZE_BITS   = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  hcbd_stream_if.sink           stream,
  hcbd_result_if.source         result
);

  logic [7:0]  max_line;
  logic        push_valid;
  byte_class_t push_item;
  logic        push_ready;
  logic        pop_valid;
  byte_class_t pop_item;
  logic        pop_ready;
  logic        cfg_write;

  // APB register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_MAX_LINE_ADDR);
  assign prdata    = (paddr == REG_MAX_LINE_ADDR) ?
                     {{(APB_DATA_W-8){1'b0}}, max_line} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line <= MAX_LINE_RESET;
    end else if (cfg_write) begin
      max_line <= pwdata[7:0];
    end
  end

  hcbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  hcbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_line  (max_line),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .result    (result)
  );

  `HCBD_NEVER(a_payload_zero, result.valid && (result.kind != KIND_PAYLOAD) && ((result.payload_byte != 8'd0) || result.chunk_end), "non-payload result carries data")
  `HCBD_ASSERT(a_cfg_applied, cfg_write |=> (max_line == $past(pwdata[7:0])), "register write lost")
  `HCBD_ASSERT(a_queue_holds, (push_valid && !push_ready) |=> push_valid, "front dropped a byte")

endmodule

FILE: rtl/core/hcbd_front.sv
// Front stage: accepts raw bytes and registers them with their character class.
// Depends on hcbd_pkg and hcbd_stream_if.
module hcbd_front import hcbd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  hcbd_stream_if.sink         stream,
  output logic                push_valid,
  output byte_class_t         push_item,
  input  logic                push_ready
);

  logic        item_valid;
  byte_class_t item;
  byte_class_t item_next;
  logic        is_digit;
  logic        is_alpha;

  // Classify the incoming byte
  always_comb begin
    is_digit = (stream.in_byte >= 8'h30) && (stream.in_byte <= 8'h39);
    is_alpha = ((stream.in_byte >= 8'h61) && (stream.in_byte <= 8'h66)) ||
               ((stream.in_byte >= 8'h41) && (stream.in_byte <= 8'h46));
    item_next.data     = stream.in_byte;
    item_next.is_hex   = is_digit || is_alpha;
    item_next.hex_val  = is_digit ? stream.in_byte[3:0] : stream.in_byte[3:0] + 4'd9;
    item_next.is_space = (stream.in_byte == 8'h20) ||
                         ((stream.in_byte >= 8'h09) && (stream.in_byte <= 8'h0d));
    item_next.is_cr    = (stream.in_byte == 8'h0d);
    item_next.is_lf    = (stream.in_byte == 8'h0a);
  end

  // Take a new byte whenever the stage is empty or drains this cycle
  assign stream.ready = !item_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (stream.ready) begin
      item_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      item <= item_next;
    end
  end

  assign push_valid = item_valid;
  assign push_item  = item;

endmodule

FILE: rtl/core/hcbd_queue.sv
// Short FIFO of classified bytes between the front and back stages.
// Depends on hcbd_pkg; DEPTH must be a power of two, at least 2.
module hcbd_queue import hcbd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  input  byte_class_t push_item,
  output logic        push_ready,
  output logic        pop_valid,
  output byte_class_t pop_item,
  input  logic        pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  byte_class_t        slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/hcbd_back.sv
// Back stage: size line parser, payload counter and result register.
// Depends on hcbd_pkg, hcbd_result_if and the assertion macro header.
`include "http_chunked_body_decoder_macros.svh"
module hcbd_back import hcbd_pkg::*; #(
  parameter int SIZE_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   max_line,
  input  logic         pop_valid,
  input  byte_class_t  pop_item,
  output logic         pop_ready,
  hcbd_result_if.source result
);

  localparam logic [2:0] PH_LINE = 3'd0;
  localparam logic [2:0] PH_DATA = 3'd1;
  localparam logic [2:0] PH_SKIP = 3'd2;
  localparam logic [2:0] PH_DONE = 3'd3;
  localparam logic [2:0] PH_ERR  = 3'd4;

  logic [2:0]           phase, phase_next;
  logic [SIZE_BITS-1:0] remaining, remaining_next;
  logic [7:0]           line_count, line_count_next;
  logic                 saw_digit, saw_digit_next;
  logic                 in_ext, in_ext_next;
  logic                 prev_cr, prev_cr_next;
  logic [1:0]           skip_count, skip_count_next;

  logic                 out_valid;
  kind_t                out_kind, kind_next;
  logic [7:0]           out_payload, payload_next;
  logic                 out_last, last_next;

  logic                 pop;
  logic                 pending_cr;
  logic                 err_cr;
  logic [7:0]           lc_cr;
  logic                 ext_cr;
  logic [1:0]           skip_dec;

  assign pop_ready = !out_valid || result.ready;
  assign pop       = pop_valid && pop_ready;

  // Step the decoder by one byte
  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    line_count_next = line_count;
    saw_digit_next  = saw_digit;
    in_ext_next     = in_ext;
    prev_cr_next    = prev_cr;
    skip_count_next = skip_count;
    kind_next       = KIND_IGNORED;
    payload_next    = '0;
    last_next       = 1'b0;

    // A held CR not followed by LF counts as a content byte first
    pending_cr = prev_cr && !pop_item.is_lf;
    err_cr     = pending_cr && (line_count >= max_line);
    lc_cr      = pending_cr ? line_count + 8'd1 : line_count;
    ext_cr     = in_ext || (pending_cr && saw_digit);
    skip_dec   = (skip_count != '0) ? skip_count - 2'd1 : skip_count;

    case (phase)
      PH_LINE: begin
        if (prev_cr && pop_item.is_lf) begin
          if (!saw_digit) begin
            phase_next = PH_ERR;
            kind_next  = KIND_ERROR;
          end else begin
            prev_cr_next = 1'b0;
            if (remaining == '0) begin
              phase_next = PH_DONE;
              kind_next  = KIND_COMPLETE;
            end else begin
              phase_next = PH_DATA;
              kind_next  = KIND_FRAME;
            end
          end
        end else begin
          kind_next       = KIND_FRAME;
          line_count_next = lc_cr;
          in_ext_next     = ext_cr;
          prev_cr_next    = 1'b0;
          if (err_cr) begin
            phase_next = PH_ERR;
            kind_next  = KIND_ERROR;
          end else if (pop_item.is_cr) begin
            prev_cr_next = 1'b1;
          end else if (lc_cr >= max_line) begin
            phase_next = PH_ERR;
            kind_next  = KIND_ERROR;
          end else begin
            line_count_next = lc_cr + 8'd1;
            if (ext_cr || (!saw_digit && pop_item.is_space)) begin
              // skip whitespace or extension text
            end else if (!pop_item.is_hex) begin
              in_ext_next = 1'b1;
            end else if (remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
              phase_next = PH_ERR;
              kind_next  = KIND_ERROR;
            end else begin
              remaining_next = {remaining[SIZE_BITS-5:0], pop_item.hex_val};
              saw_digit_next = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        kind_next    = KIND_PAYLOAD;
        payload_next = pop_item.data;
        if (remaining != '0) remaining_next = remaining - 1'b1;
        if (remaining[SIZE_BITS-1:1] == '0) begin
          last_next       = 1'b1;
          phase_next      = PH_SKIP;
          skip_count_next = 2'd2;
        end
      end
      PH_SKIP: begin
        kind_next       = KIND_FRAME;
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next      = PH_LINE;
          remaining_next  = '0;
          line_count_next = '0;
          saw_digit_next  = 1'b0;
          in_ext_next     = 1'b0;
          prev_cr_next    = 1'b0;
        end
      end
      default: begin
        kind_next = KIND_IGNORED;
      end
    endcase
  end

  // Commit state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LINE;
      remaining  <= '0;
      line_count <= '0;
      saw_digit  <= 1'b0;
      in_ext     <= 1'b0;
      prev_cr    <= 1'b0;
      skip_count <= '0;
    end else if (pop) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      line_count <= line_count_next;
      saw_digit  <= saw_digit_next;
      in_ext     <= in_ext_next;
      prev_cr    <= prev_cr_next;
      skip_count <= skip_count_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind    <= kind_next;
      out_payload <= payload_next;
      out_last    <= last_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = out_kind;
  assign result.payload_byte = out_payload;
  assign result.chunk_end    = out_last;

  `HCBD_NEVER(a_data_nonzero, (phase == PH_DATA) && (remaining == '0), "payload phase with no bytes left")
  `HCBD_NEVER(a_skip_nonzero, (phase == PH_SKIP) && (skip_count == '0), "skip phase with zero count")
  `HCBD_ASSERT(a_done_sticky, (phase == PH_DONE) |=> (phase == PH_DONE), "left end of body")
  `HCBD_ASSERT(a_err_sticky, (phase == PH_ERR) |=> (phase == PH_ERR), "left error phase")

endmodule
